@@ sv/tkbd_pkg.sv @@
// Shared types, widths and register index codes for the touch key baseline detector.
`timescale 1ns / 1ps
package tkbd_pkg;

  localparam int unsigned NUM_KEYS_DEF    = 2;
  localparam int unsigned CAL_SAMPLES_DEF = 20;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DB_W      = 12;
  localparam int unsigned CAL_CNT_W = 5;
  localparam int unsigned CAL_SUM_W = 21;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MARGIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_REBASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CLEAR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_REBASE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_COUNT    = 3'd6;

  localparam logic [DB_W-1:0]     DEADBAND_RST       = 12'd15;
  localparam logic [SAMPLE_W-1:0] PRESS_MARGIN_RST   = 16'd120;
  localparam logic [SAMPLE_W-1:0] RELEASE_MARGIN_RST = 16'd10;
  localparam logic [SAMPLE_W-1:0] PRESS_REBASE_RST   = 16'd5000;
  localparam logic [SAMPLE_W-1:0] RELEASE_CLEAR_RST  = 16'd100;
  localparam logic [SAMPLE_W-1:0] RELEASE_REBASE_RST = 16'd1000;
  localparam logic [SAMPLE_W-1:0] FOCUS_COUNT_RST    = 16'd50;

  typedef struct packed {
    logic                key;
    logic [SAMPLE_W-1:0] sample;
  } tkbd_item_t;

  typedef struct packed {
    logic [DB_W-1:0]     deadband;
    logic [SAMPLE_W-1:0] press_margin;
    logic [SAMPLE_W-1:0] release_margin;
    logic [SAMPLE_W-1:0] press_rebase_limit;
    logic [SAMPLE_W-1:0] release_clear_limit;
    logic [SAMPLE_W-1:0] release_rebase_limit;
    logic [SAMPLE_W-1:0] focus_count;
  } tkbd_cfg_t;

  typedef struct packed {
    logic                key;
    logic                level;
    logic                toggled;
    logic                calibrating;
    logic [SAMPLE_W-1:0] filtered;
    logic [SAMPLE_W-1:0] baseline;
  } tkbd_result_t;

endpackage

@@ sv/touch_key_baseline_detector_unit.sv @@
// Top level of the touch key baseline detector: configuration registers and stage wiring.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o  key_i, sample_count_i
//   out      output     out_valid_o / out_stall_i key_out_o, output_level_o, toggled_o,
//                                                 calibrating_o, filtered_level_o,
//                                                 baseline_level_o
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One word is taken per cycle unless the input stalls; each result is registered.
// The per-key update is a combinational read-modify-write of flip-flop state.
// Reset clears all key state and loads the register defaults; no clearing pass is needed.
// A stalled output backs up into the queue; the input stalls once queue and input register are full.
`timescale 1ns / 1ps
module touch_key_baseline_detector_unit #(
  parameter int unsigned NUM_KEYS    = tkbd_pkg::NUM_KEYS_DEF,
  parameter int unsigned CAL_SAMPLES = tkbd_pkg::CAL_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          key_i,
  input  logic [tkbd_pkg::SAMPLE_W-1:0]  sample_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          key_out_o,
  output logic                          output_level_o,
  output logic                          toggled_o,
  output logic                          calibrating_o,
  output logic [tkbd_pkg::SAMPLE_W-1:0]  filtered_level_o,
  output logic [tkbd_pkg::SAMPLE_W-1:0]  baseline_level_o,
  input  logic                          cfg_we_i,
  input  logic [tkbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tkbd_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import tkbd_pkg::*;

  tkbd_cfg_t    cfg_q, cfg_d;
  logic         push, queue_full, queue_not_empty, pop;
  tkbd_item_t   push_item, pop_item;
  tkbd_result_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEADBAND:       cfg_d.deadband             = cfg_data_i[DB_W-1:0];
        CFG_PRESS_MARGIN:   cfg_d.press_margin         = cfg_data_i;
        CFG_RELEASE_MARGIN: cfg_d.release_margin       = cfg_data_i;
        CFG_PRESS_REBASE:   cfg_d.press_rebase_limit   = cfg_data_i;
        CFG_RELEASE_CLEAR:  cfg_d.release_clear_limit  = cfg_data_i;
        CFG_RELEASE_REBASE: cfg_d.release_rebase_limit = cfg_data_i;
        CFG_FOCUS_COUNT:    cfg_d.focus_count          = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband             <= DEADBAND_RST;
      cfg_q.press_margin         <= PRESS_MARGIN_RST;
      cfg_q.release_margin       <= RELEASE_MARGIN_RST;
      cfg_q.press_rebase_limit   <= PRESS_REBASE_RST;
      cfg_q.release_clear_limit  <= RELEASE_CLEAR_RST;
      cfg_q.release_rebase_limit <= RELEASE_REBASE_RST;
      cfg_q.focus_count          <= FOCUS_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tkbd_front #(
    .NUM_KEYS(NUM_KEYS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_i         (key_i),
    .sample_count_i(sample_count_i),
    .push_o        (push),
    .push_item_o   (push_item),
    .queue_full_i  (queue_full)
  );

  tkbd_queue #(
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (queue_full),
    .not_empty_o(queue_not_empty),
    .pop_i      (pop),
    .pop_item_o (pop_item)
  );

  tkbd_back #(
    .NUM_KEYS   (NUM_KEYS),
    .CAL_SAMPLES(CAL_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(queue_not_empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign key_out_o        = res.key;
  assign output_level_o   = res.level;
  assign toggled_o        = res.toggled;
  assign calibrating_o    = res.calibrating;
  assign filtered_level_o = res.filtered;
  assign baseline_level_o = res.baseline;

endmodule

@@ sv/tkbd_front.sv @@
// Input stage: takes words, drops keys out of range and pushes the rest toward the queue.
`timescale 1ns / 1ps
module tkbd_front #(
  parameter int unsigned NUM_KEYS = tkbd_pkg::NUM_KEYS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         key_i,
  input  logic [tkbd_pkg::SAMPLE_W-1:0] sample_count_i,
  output logic                         push_o,
  output tkbd_pkg::tkbd_item_t         push_item_o,
  input  logic                         queue_full_i
);
  import tkbd_pkg::*;

  logic       valid_q, valid_d;
  tkbd_item_t item_q, item_d;
  logic       key_ok;
  logic       take;

  // Key indexes at or above the key count produce no result and are dropped here.
  assign key_ok     = (32'(key_i) < NUM_KEYS);
  assign push_o     = valid_q && !queue_full_i;
  assign in_stall_o = valid_q && queue_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (take && key_ok) begin
      valid_d       = 1'b1;
      item_d.key    = key_i;
      item_d.sample = sample_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ sv/tkbd_queue.sv @@
// Short queue of words between the input stage and the per-key update stage.
`timescale 1ns / 1ps
module tkbd_queue #(
  parameter int unsigned DEPTH = tkbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tkbd_pkg::tkbd_item_t push_item_i,
  output logic                 full_o,
  output logic                 not_empty_o,
  input  logic                 pop_i,
  output tkbd_pkg::tkbd_item_t pop_item_o
);
  import tkbd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tkbd_item_t          mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o      = (cnt_q == CntW'(DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ sv/tkbd_back.sv @@
// Per-key state update: calibration averaging, deadband filter, press and release tracking.
`timescale 1ns / 1ps
module tkbd_back #(
  parameter int unsigned NUM_KEYS    = tkbd_pkg::NUM_KEYS_DEF,
  parameter int unsigned CAL_SAMPLES = tkbd_pkg::CAL_SAMPLES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tkbd_pkg::tkbd_cfg_t    cfg_i,
  input  logic                   item_valid_i,
  input  tkbd_pkg::tkbd_item_t   item_i,
  output logic                   pop_o,
  output logic                   res_valid_o,
  input  logic                   res_stall_i,
  output tkbd_pkg::tkbd_result_t res_o
);
  import tkbd_pkg::*;

  localparam int unsigned KeyIdxW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  // Exact division of the calibration sum by a reciprocal multiply.
  localparam int unsigned CalShift = CAL_SUM_W + $clog2(CAL_SAMPLES);
  localparam longint unsigned CalMult =
    ((64'd1 << CalShift) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int unsigned CalMultW = $clog2(CalMult + 1);
  localparam int unsigned ProdW    = CAL_SUM_W + CalMultW;
  localparam int unsigned CmpW     = SAMPLE_W + 1;

  logic [SAMPLE_W-1:0]  filt_q   [NUM_KEYS];
  logic [SAMPLE_W-1:0]  base_q   [NUM_KEYS];
  logic [SAMPLE_W-1:0]  press_q  [NUM_KEYS];
  logic [SAMPLE_W-1:0]  rel_q    [NUM_KEYS];
  logic                 lvl_q    [NUM_KEYS];
  logic [CAL_CNT_W-1:0] ccnt_q   [NUM_KEYS];
  logic [CAL_SUM_W-1:0] csum_q   [NUM_KEYS];

  logic                 res_valid_q, res_valid_d;
  tkbd_result_t         res_q, res_d;

  logic [KeyIdxW-1:0]   idx;
  logic [SAMPLE_W-1:0]  filt_d, base_d, press_d, rel_d;
  logic                 lvl_d, tog, cal;
  logic [CAL_CNT_W-1:0] ccnt_d;
  logic [CAL_SUM_W-1:0] csum_d;
  logic [ProdW-1:0]     prod;
  logic [CmpW-1:0]      s_x, f_x, fn_x, b_x, pc_inc, rc_inc;
  logic                 take_s, pressed, released;

  assign pop_o = item_valid_i && (!res_valid_q || !res_stall_i);
  assign idx   = KeyIdxW'(item_i.key);

  always_comb begin
    filt_d  = filt_q[idx];
    base_d  = base_q[idx];
    press_d = press_q[idx];
    rel_d   = rel_q[idx];
    lvl_d   = lvl_q[idx];
    ccnt_d  = ccnt_q[idx];
    csum_d  = csum_q[idx];
    tog     = 1'b0;
    cal     = (ccnt_q[idx] < CAL_CNT_W'(CAL_SAMPLES));

    csum_d = csum_q[idx] + CAL_SUM_W'(item_i.sample);
    prod   = ProdW'(csum_d) * ProdW'(CalMult);
    s_x    = CmpW'(item_i.sample);
    f_x    = CmpW'(filt_q[idx]);
    b_x    = CmpW'(base_q[idx]);
    take_s = (s_x > f_x + CmpW'(cfg_i.deadband)) || (s_x + CmpW'(cfg_i.deadband) < f_x);
    fn_x   = take_s ? s_x : f_x;
    pressed  = (fn_x + CmpW'(cfg_i.press_margin) < b_x);
    released = (fn_x + CmpW'(cfg_i.release_margin) > b_x);
    pc_inc = CmpW'(press_q[idx]) + CmpW'(1);
    rc_inc = CmpW'(rel_q[idx]) + CmpW'(1);

    if (cal) begin
      ccnt_d = ccnt_q[idx] + 1'b1;
      if (ccnt_d >= CAL_CNT_W'(CAL_SAMPLES)) begin
        base_d = prod[CalShift +: SAMPLE_W];
      end
    end else begin
      csum_d = csum_q[idx];
      filt_d = fn_x[SAMPLE_W-1:0];
      if (pressed) begin
        if (pc_inc > CmpW'(cfg_i.press_rebase_limit)) begin
          press_d = '0;
          base_d  = fn_x[SAMPLE_W-1:0];
        end else begin
          press_d = pc_inc[SAMPLE_W-1:0];
        end
      end else if (released) begin
        if (rc_inc > CmpW'(cfg_i.release_clear_limit)) begin
          press_d = '0;
        end
        if (rc_inc > CmpW'(cfg_i.release_rebase_limit)) begin
          rel_d  = '0;
          base_d = fn_x[SAMPLE_W-1:0];
        end else begin
          rel_d = rc_inc[SAMPLE_W-1:0];
        end
      end
      if (press_d == cfg_i.focus_count) begin
        lvl_d = !lvl_q[idx];
        tog   = 1'b1;
      end
    end

    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (res_valid_q && !res_stall_i) begin
      res_valid_d = 1'b0;
    end
    if (pop_o) begin
      res_valid_d       = 1'b1;
      res_d.key         = item_i.key;
      res_d.level       = lvl_d;
      res_d.toggled     = tog;
      res_d.calibrating = cal;
      res_d.filtered    = filt_d;
      res_d.baseline    = base_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        filt_q[k]  <= '0;
        base_q[k]  <= '0;
        press_q[k] <= '0;
        rel_q[k]   <= '0;
        lvl_q[k]   <= 1'b0;
        ccnt_q[k]  <= '0;
        csum_q[k]  <= '0;
      end
    end else begin
      res_valid_q <= res_valid_d;
      if (pop_o) begin
        filt_q[idx]  <= filt_d;
        base_q[idx]  <= base_d;
        press_q[idx] <= press_d;
        rel_q[idx]   <= rel_d;
        lvl_q[idx]   <= lvl_d;
        ccnt_q[idx]  <= ccnt_d;
        csum_q[idx]  <= csum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ dv/tkbd_scoreboard_pkg.sv @@
// Scoreboard class for the touch key baseline detector: per-key predictor and result queue.
`timescale 1ns / 1ps
package tkbd_scoreboard_pkg;
  import tkbd_pkg::*;

  class tkbd_scoreboard;
    logic [SAMPLE_W-1:0]  filt     [NUM_KEYS_DEF];
    logic [SAMPLE_W-1:0]  base     [NUM_KEYS_DEF];
    logic [SAMPLE_W-1:0]  presses  [NUM_KEYS_DEF];
    logic [SAMPLE_W-1:0]  releases [NUM_KEYS_DEF];
    logic                 level    [NUM_KEYS_DEF];
    logic [CAL_CNT_W-1:0] cal_n    [NUM_KEYS_DEF];
    logic [CAL_SUM_W-1:0] cal_acc  [NUM_KEYS_DEF];

    logic [DB_W-1:0]     db;
    logic [SAMPLE_W-1:0] pm;
    logic [SAMPLE_W-1:0] rm;
    logic [SAMPLE_W-1:0] press_limit;
    logic [SAMPLE_W-1:0] clear_limit;
    logic [SAMPLE_W-1:0] rebase_limit;
    logic [SAMPLE_W-1:0] focus;

    tkbd_result_t expected_q[$];
    int errors;

    function new();
      errors       = 0;
      db           = DEADBAND_RST;
      pm           = PRESS_MARGIN_RST;
      rm           = RELEASE_MARGIN_RST;
      press_limit  = PRESS_REBASE_RST;
      clear_limit  = RELEASE_CLEAR_RST;
      rebase_limit = RELEASE_REBASE_RST;
      focus        = FOCUS_COUNT_RST;
      for (int k = 0; k < NUM_KEYS_DEF; k++) begin
        filt[k]     = '0;
        base[k]     = '0;
        presses[k]  = '0;
        releases[k] = '0;
        level[k]    = 1'b0;
        cal_n[k]    = '0;
        cal_acc[k]  = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
      case (idx)
        CFG_DEADBAND:       db = d[DB_W-1:0];
        CFG_PRESS_MARGIN:   pm = d;
        CFG_RELEASE_MARGIN: rm = d;
        CFG_PRESS_REBASE:   press_limit = d;
        CFG_RELEASE_CLEAR:  clear_limit = d;
        CFG_RELEASE_REBASE: rebase_limit = d;
        CFG_FOCUS_COUNT:    focus = d;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_word(logic k, logic [SAMPLE_W-1:0] s);
      tkbd_result_t r;
      int si;
      int fi;
      int bi;
      int pc;
      int rc;
      logic tog;
      logic cal;
      tog = 1'b0;
      cal = 1'b0;
      if (cal_n[k] < CAL_SAMPLES_DEF) begin
        cal        = 1'b1;
        cal_acc[k] = cal_acc[k] + CAL_SUM_W'(s);
        cal_n[k]   = cal_n[k] + 1'b1;
        if (cal_n[k] >= CAL_SAMPLES_DEF) base[k] = SAMPLE_W'(cal_acc[k] / CAL_SAMPLES_DEF);
      end else begin
        si = int'(s);
        fi = int'(filt[k]);
        if (si > fi + int'(db) || si < fi - int'(db)) filt[k] = s;
        fi = int'(filt[k]);
        bi = int'(base[k]);
        if (fi < bi - int'(pm)) begin
          pc = int'(presses[k]) + 1;
          if (pc > int'(press_limit)) begin
            pc      = 0;
            base[k] = filt[k];
          end
          presses[k] = pc[SAMPLE_W-1:0];
        end else if (fi > bi - int'(rm)) begin
          rc = int'(releases[k]) + 1;
          if (rc > int'(clear_limit)) presses[k] = '0;
          if (rc > int'(rebase_limit)) begin
            rc      = 0;
            base[k] = filt[k];
          end
          releases[k] = rc[SAMPLE_W-1:0];
        end
        if (presses[k] == focus) begin
          level[k] = ~level[k];
          tog      = 1'b1;
        end
      end
      r.key         = k;
      r.level       = level[k];
      r.toggled     = tog;
      r.calibrating = cal;
      r.filtered    = filt[k];
      r.baseline    = base[k];
      expected_q.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 100) $display("%0t: mismatch: %s", $time, msg);
    endfunction

    function void compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
    endfunction

    function void check_word(tkbd_result_t got);
      tkbd_result_t want;
      if (expected_q.size() == 0) begin
        report("result word with no word pending");
        return;
      end
      want = expected_q.pop_front();
      compare_field("key_out", 32'(got.key), 32'(want.key));
      compare_field("output_level", 32'(got.level), 32'(want.level));
      compare_field("toggled", 32'(got.toggled), 32'(want.toggled));
      compare_field("calibrating", 32'(got.calibrating), 32'(want.calibrating));
      compare_field("filtered_level", 32'(got.filtered), 32'(want.filtered));
      compare_field("baseline_level", 32'(got.baseline), 32'(want.baseline));
    endfunction
  endclass

endpackage

@@ dv/tb_touch_key_baseline_detector_unit.sv @@
// Testbench top for the touch key baseline detector: stimulus, stall pattern and checking.
`timescale 1ns / 1ps
module tb_touch_key_baseline_detector_unit;
  import tkbd_pkg::*;
  import tkbd_scoreboard_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef enum logic [1:0] {SEG_REST, SEG_TOUCH, SEG_HOVER, SEG_NOISE} seg_e;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_key    = 1'b0;
  logic [SAMPLE_W-1:0]  in_sample = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic [31:0]          cycle_n   = '0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 key_out_o;
  logic                 output_level_o;
  logic                 toggled_o;
  logic                 calibrating_o;
  logic [SAMPLE_W-1:0]  filtered_level_o;
  logic [SAMPLE_W-1:0]  baseline_level_o;

  tkbd_scoreboard sb;
  int   burst_left = 0;
  seg_e seg_mode [NUM_KEYS_DEF];
  int   seg_left [NUM_KEYS_DEF];

  touch_key_baseline_detector_unit uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .key_i            (in_key),
    .sample_count_i   (in_sample),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .key_out_o        (key_out_o),
    .output_level_o   (output_level_o),
    .toggled_o        (toggled_o),
    .calibrating_o    (calibrating_o),
    .filtered_level_o (filtered_level_o),
    .baseline_level_o (baseline_level_o),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    case (cycle_n[8:7])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= (cycle_n[2:0] < 3'd3);
      default: out_stall <= 1'($urandom_range(0, 1));
    endcase
    if (cycle_n > CYCLE_LIMIT) begin
      $display("[touch_key_baseline_detector_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    tkbd_result_t got;
    if (rst_n && out_valid_o && !out_stall) begin
      got.key         = key_out_o;
      got.level       = output_level_o;
      got.toggled     = toggled_o;
      got.calibrating = calibrating_o;
      got.filtered    = filtered_level_o;
      got.baseline    = baseline_level_o;
      sb.check_word(got);
    end
  end

  task automatic send_word(input logic k, input logic [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 7) ? 0 : int'($urandom_range(1, 8));
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_key    <= k;
    in_sample <= s;
    do @(posedge clk); while (in_stall_o);
    sb.note_word(k, s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic apply_setting(input logic [CFG_DAT_W-1:0] dband, pmar, rmar, prl, rcl, rrl,
                               fcnt, input bit poke_unused);
    write_reg(CFG_DEADBAND, dband);
    write_reg(CFG_PRESS_MARGIN, pmar);
    write_reg(CFG_RELEASE_MARGIN, rmar);
    write_reg(CFG_PRESS_REBASE, prl);
    write_reg(CFG_RELEASE_CLEAR, rcl);
    write_reg(CFG_RELEASE_REBASE, rrl);
    write_reg(CFG_FOCUS_COUNT, fcnt);
    if (poke_unused) write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Samples follow touch-like segments around the key's current baseline, with some noise.
  task automatic next_word(output logic k, output logic [SAMPLE_W-1:0] s);
    int v;
    int b;
    int r;
    k = 1'($urandom_range(0, 1));
    if (seg_left[k] == 0) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        seg_mode[k] = SEG_REST;
        seg_left[k] = $urandom_range(1, 70);
      end else if (r < 80) begin
        seg_mode[k] = SEG_TOUCH;
        seg_left[k] = $urandom_range(1, 70);
      end else if (r < 90) begin
        seg_mode[k] = SEG_HOVER;
        seg_left[k] = $urandom_range(1, 10);
      end else begin
        seg_mode[k] = SEG_NOISE;
        seg_left[k] = $urandom_range(1, 4);
      end
    end
    seg_left[k]--;
    b = int'(sb.base[k]);
    case (seg_mode[k])
      SEG_REST:  v = b + int'($urandom_range(0, 40)) - int'($urandom_range(0, 8));
      SEG_TOUCH: v = b - int'(sb.pm) - int'($urandom_range(1, 200));
      SEG_HOVER: v = b - int'($urandom_range(sb.rm, sb.pm));
      default:   v = int'($urandom_range(0, 65535));
    endcase
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    s = v[SAMPLE_W-1:0];
  endtask

  initial begin
    int p;
    int n;
    logic k;
    logic [SAMPLE_W-1:0] s;
    sb = new();
    for (int i = 0; i < NUM_KEYS_DEF; i++) begin
      seg_mode[i] = SEG_REST;
      seg_left[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Calibrate one key at full scale and the other at zero, then probe the filter start.
    for (int i = 0; i < CAL_SAMPLES_DEF; i++) send_word(1'b0, 16'hFFFF);
    for (int i = 0; i < CAL_SAMPLES_DEF; i++) send_word(1'b1, 16'h0000);
    send_word(1'b1, 16'd0);
    send_word(1'b1, 16'd15);
    send_word(1'b1, 16'd16);
    send_word(1'b0, 16'hFFFF);
    send_word(1'b0, 16'd0);
    send_word(1'b0, 16'd0);
    send_word(1'b1, 16'd0);
    send_word(1'b1, 16'h8000);
    drain();

    for (p = 1; p <= 9; p++) begin
      case (p)
        1: apply_setting(16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 1'b0);
        3: apply_setting(16'h0000, 16'd40, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
        default: apply_setting(16'({4'($urandom_range(0, 15)), 12'($urandom_range(0, 40))}),
                               16'($urandom_range(40, 400)), 16'($urandom_range(0, 60)),
                               16'($urandom_range(5, 80)), 16'($urandom_range(2, 30)),
                               16'($urandom_range(5, 80)), 16'($urandom_range(1, 30)),
                               1'b0);
      endcase
      for (n = 0; n < 72; n++) begin
        if (p == 4 && n == 36) drain();
        next_word(k, s);
        send_word(k, s);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected result words never arrived");
    if (sb.errors == 0) begin
      $display("[touch_key_baseline_detector_unit] OK");
    end else begin
      $display("[touch_key_baseline_detector_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/tkbd_pkg.sv
sv/tkbd_front.sv
sv/tkbd_queue.sv
sv/tkbd_back.sv
sv/touch_key_baseline_detector_unit.sv
dv/tkbd_scoreboard_pkg.sv
dv/tb_touch_key_baseline_detector_unit.sv
